@@ rtl/cfre_pkg.sv @@
// ----------------------------------------------------------------------------
// cfre_pkg
// Shared types and constants of the camera-facing ribbon expander.
// ----------------------------------------------------------------------------
package cfre_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned WidthW    = 31;
  localparam int unsigned SlotW     = 11;
  localparam int unsigned CntW      = 11;
  localparam int unsigned StepW     = 5;
  localparam int unsigned VecW      = 34;
  localparam int unsigned MagW      = 33;
  localparam int unsigned AccW      = 44;
  localparam int unsigned LenW      = 22;
  localparam int unsigned QuoW      = 31;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam int unsigned SqSteps   = 3;
  localparam int unsigned RootSteps = 21;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned CrossSteps = 6;
  localparam int unsigned OffsSteps = 3;

  localparam logic [MagW-1:0] NormHi     = MagW'(1) << 20;
  localparam logic [MagW-1:0] NormLo     = MagW'(1) << 19;
  localparam logic [MagW-1:0] SmallLimit = MagW'(66);
  localparam logic [MagW-1:0] BigLimit   = MagW'(1) << 21;
  localparam logic [AccW-1:0] SmallEps   = AccW'(4295);
  localparam logic [AccW-1:0] BigEps     = AccW'(64'd1152921504607);
  localparam logic signed [VecW-1:0] OneQ30 = VecW'(1) << 30;

  localparam logic [WidthW-1:0] WidthReset = WidthW'(65536);
  localparam logic [ColorW-1:0] ColorReset = '1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT,
    ST_LONG
  } status_e;

  typedef enum logic [2:0] {
    REG_CAM_X,
    REG_CAM_Y,
    REG_CAM_Z,
    REG_WIDTH,
    REG_COLOR
  } reg_e;

  typedef enum logic [1:0] {
    V_TAN,
    V_CAM,
    V_SIDE
  } vsel_e;

  typedef enum logic [1:0] {
    EM_LEFT,
    EM_RIGHT,
    EM_ERR
  } emit_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_COMMIT,
    OP_VLOAD,
    OP_MAGLOAD,
    OP_SQ,
    OP_TINY,
    OP_SHR,
    OP_SHL,
    OP_ROOT,
    OP_DIV,
    OP_STORE,
    OP_STORE_ZERO,
    OP_CROSS,
    OP_OFFS,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [StepW-1:0] cnt;
    vsel_e            vsel;
    logic             retry;
    logic             pass;
    logic             use_older;
    logic [CntW-1:0]  idx;
    emit_e            emit;
    status_e          err;
  } cmd_t;

  typedef struct packed {
    logic tiny;
    logic m_zero;
    logic m_hi;
    logic m_lo;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/cfre_in_if.sv @@
// ----------------------------------------------------------------------------
// cfre_in_if
// Point channel: valid/ready handshake with one polyline point per word.
// ----------------------------------------------------------------------------
interface cfre_in_if import cfre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;
  logic                     end_of_line;

  modport source(output valid, point_x, point_y, point_z, end_of_line, input ready);
  modport sink(input valid, point_x, point_y, point_z, end_of_line, output ready);
endinterface

@@ rtl/cfre_out_if.sv @@
// ----------------------------------------------------------------------------
// cfre_out_if
// Vertex channel: valid/ready handshake with one ribbon vertex per word.
// ----------------------------------------------------------------------------
interface cfre_out_if import cfre_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vert_x;
  logic signed [CoordW-1:0] vert_y;
  logic signed [CoordW-1:0] vert_z;
  logic [ColorW-1:0]        vert_rgba;
  logic [SlotW-1:0]         vert_slot;
  logic                     run_last;
  logic [1:0]               status;

  modport source(output valid, vert_x, vert_y, vert_z, vert_rgba, vert_slot, run_last,
                 status, input ready);
  modport sink(input valid, vert_x, vert_y, vert_z, vert_rgba, vert_slot, run_last,
               status, output ready);
endinterface

@@ rtl/cfre_dp.sv @@
// ----------------------------------------------------------------------------
// cfre_dp
// Datapath: point history, vector unit with shared multiplier, square root,
// three divider lanes, offset scaling and the output register.
// ----------------------------------------------------------------------------
module cfre_dp import cfre_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic signed [CoordW-1:0] cam_x_i,
  input  logic signed [CoordW-1:0] cam_y_i,
  input  logic signed [CoordW-1:0] cam_z_i,
  input  logic [WidthW-1:0]        width_i,
  input  logic [ColorW-1:0]        color_i,
  cfre_out_if.source               out_o
);

  typedef logic signed [CoordW-1:0] crd_t;
  typedef logic signed [VecW-1:0]   vec_t;

  function automatic logic [1:0] nxt1(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] j);
    logic [1:0] r;
    unique case (j)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  crd_t newp_q [3];
  crd_t pend_q [3];
  crd_t old_q  [3];
  vec_t vec_q  [3];
  logic [MagW-1:0] mag_q [3];
  logic            neg_q [3];
  logic [AccW-1:0] acc_q;
  logic [AccW-1:0] rt_n_q, rt_res_q;
  logic [LenW-1:0] rem_q [3];
  logic [QuoW-1:0] quo_q [3];
  crd_t tn_q  [3];
  crd_t cn_q  [3];
  crd_t sn_q  [3];
  crd_t off_q [3];
  logic signed [63:0] xp_q;

  logic                     out_vld_q;
  logic signed [CoordW-1:0] ox_q, oy_q, oz_q;
  logic [ColorW-1:0]        orgba_q;
  logic [SlotW-1:0]         oslot_q;
  logic                     olast_q;
  logic [1:0]               ostat_q;

  crd_t in_pt [3];
  crd_t cam   [3];
  crd_t pt_p  [3];
  crd_t pt_a  [3];
  vec_t vl    [3];
  vec_t vabs  [3];
  vec_t vfb   [3];
  crd_t vert  [3];
  logic [MagW-1:0] mmax;
  logic [MagW-1:0] lim;
  logic [AccW-1:0] eps;
  logic            tiny;
  logic [1:0]      li, ci, ti, xj;
  logic signed [MagW-1:0]   mul_a, mul_b;
  logic signed [2*MagW-1:0] prod;
  logic signed [63:0] p64;
  logic signed [64:0] xd;
  logic [64:0]        xdm;
  vec_t               xq;
  logic [CoordW-1:0]  sabs;
  logic [61:0]        osum;
  logic [QuoW-1:0]    om;
  logic [AccW-1:0]    rn_in, rr_in, rbit, rsum;
  logic [5:0]         rsh;
  logic [LenW:0]      trial [3];
  logic [LenW-1:0]    len;
  logic signed [CoordW:0] vsum [3];

  assign in_pt[0] = point_x_i;
  assign in_pt[1] = point_y_i;
  assign in_pt[2] = point_z_i;
  assign cam[0]   = cam_x_i;
  assign cam[1]   = cam_y_i;
  assign cam[2]   = cam_z_i;

  assign li   = cmd_i.cnt[1:0];
  assign xj   = cmd_i.cnt[2:1];
  assign len  = rt_res_q[LenW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_p[i] = cmd_i.pass ? newp_q[i] : pend_q[i];
      pt_a[i] = cmd_i.pass ? pend_q[i] : (cmd_i.use_older ? old_q[i] : pend_q[i]);
      if (cmd_i.vsel == V_TAN) begin
        vl[i] = VecW'(newp_q[i]) - VecW'(pt_a[i]);
      end else begin
        vl[i] = VecW'(cam[i]) - VecW'(pt_p[i]);
      end
      vabs[i] = vec_q[i][VecW-1] ? -vec_q[i] : vec_q[i];
    end

    mmax = mag_q[0];
    if (mag_q[1] > mmax) mmax = mag_q[1];
    if (mag_q[2] > mmax) mmax = mag_q[2];

    lim  = (cmd_i.vsel == V_SIDE) ? BigLimit : SmallLimit;
    eps  = (cmd_i.vsel == V_SIDE) ? BigEps : SmallEps;
    tiny = (mag_q[0] < lim) && (mag_q[1] < lim) && (mag_q[2] < lim) && (acc_q < eps);

    unique case (cmd_i.vsel)
      V_TAN: begin
        vfb[0] = '0; vfb[1] = OneQ30; vfb[2] = '0;
      end
      V_CAM: begin
        vfb[0] = '0; vfb[1] = '0; vfb[2] = OneQ30;
      end
      default: begin
        if (cmd_i.retry) begin
          vfb[0] = OneQ30; vfb[1] = '0; vfb[2] = '0;
        end else begin
          vfb[0] = VecW'(tn_q[2]); vfb[1] = '0; vfb[2] = -VecW'(tn_q[0]);
        end
      end
    endcase

    // cross term c[ci]*t[ti]; even step takes the first product
    ci = cmd_i.cnt[0] ? nxt2(xj) : nxt1(xj);
    ti = cmd_i.cnt[0] ? nxt1(xj) : nxt2(xj);
    sabs = sn_q[li][CoordW-1] ? CoordW'(-sn_q[li]) : CoordW'(sn_q[li]);

    unique case (cmd_i.op)
      OP_SQ: begin
        mul_a = $signed({12'b0, mag_q[li][20:0]});
        mul_b = $signed({12'b0, mag_q[li][20:0]});
      end
      OP_CROSS: begin
        mul_a = MagW'(cn_q[ci]);
        mul_b = MagW'(tn_q[ti]);
      end
      default: begin
        mul_a = $signed({2'b0, sabs[QuoW-1:0]});
        mul_b = $signed({2'b0, width_i});
      end
    endcase
    prod = mul_a * mul_b;

    p64  = prod[63:0];
    xd   = 65'(xp_q) - 65'(p64);
    xdm  = xd[64] ? 65'(-xd) : 65'(xd);
    xq   = $signed(xdm[VecW+29:30]);
    osum = prod[61:0] + (62'd1 << 30);
    om   = osum[61:31];

    rn_in = (cmd_i.cnt == '0) ? acc_q : rt_n_q;
    rr_in = (cmd_i.cnt == '0) ? '0 : rt_res_q;
    rsh   = 6'(2 * (RootSteps - 1)) - {cmd_i.cnt, 1'b0};
    rbit  = AccW'(1) << rsh;
    rsum  = rr_in + rbit;

    for (int i = 0; i < 3; i++) begin
      trial[i] = (cmd_i.cnt == '0) ? (LenW + 1)'(mag_q[i][LenW-1:0]) : {rem_q[i], 1'b0};
      if (cmd_i.emit == EM_LEFT) begin
        vsum[i] = (CoordW + 1)'(pt_p[i]) - (CoordW + 1)'(off_q[i]);
      end else begin
        vsum[i] = (CoordW + 1)'(pt_p[i]) + (CoordW + 1)'(off_q[i]);
      end
      if (vsum[i][CoordW] != vsum[i][CoordW-1]) begin
        vert[i] = vsum[i][CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      end else begin
        vert[i] = vsum[i][CoordW-1:0];
      end
    end
  end

  assign stat_o.tiny     = tiny;
  assign stat_o.m_zero   = (mmax == '0);
  assign stat_o.m_hi     = (mmax >= NormHi);
  assign stat_o.m_lo     = (mmax < NormLo);
  assign stat_o.out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        for (int i = 0; i < 3; i++) newp_q[i] <= in_pt[i];
      end
      OP_COMMIT: begin
        for (int i = 0; i < 3; i++) begin
          old_q[i]  <= pend_q[i];
          pend_q[i] <= newp_q[i];
        end
      end
      OP_VLOAD: begin
        for (int i = 0; i < 3; i++) vec_q[i] <= vl[i];
      end
      OP_MAGLOAD: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= vabs[i][MagW-1:0];
          neg_q[i] <= vec_q[i][VecW-1];
        end
      end
      OP_SQ: begin
        acc_q <= ((cmd_i.cnt == '0) ? '0 : acc_q) + AccW'(prod[41:0]);
      end
      OP_TINY: begin
        if (tiny) begin
          for (int i = 0; i < 3; i++) vec_q[i] <= vfb[i];
        end
      end
      OP_SHR: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      end
      OP_SHL: begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
      end
      OP_ROOT: begin
        if (rn_in >= rsum) begin
          rt_n_q   <= rn_in - rsum;
          rt_res_q <= (rr_in >> 1) + rbit;
        end else begin
          rt_n_q   <= rn_in;
          rt_res_q <= rr_in >> 1;
        end
      end
      // all quotient bits are shifted in over the full step count
      OP_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= (LenW + 1)'(len)) begin
            rem_q[i] <= LenW'(trial[i] - (LenW + 1)'(len));
            quo_q[i] <= {quo_q[i][QuoW-2:0], 1'b1};
          end else begin
            rem_q[i] <= trial[i][LenW-1:0];
            quo_q[i] <= {quo_q[i][QuoW-2:0], 1'b0};
          end
        end
      end
      OP_STORE, OP_STORE_ZERO: begin
        for (int i = 0; i < 3; i++) begin
          crd_t u;
          u = (cmd_i.op == OP_STORE_ZERO) ? '0
            : (neg_q[i] ? -CoordW'(quo_q[i]) : CoordW'(quo_q[i]));
          unique case (cmd_i.vsel)
            V_TAN:   tn_q[i] <= u;
            V_CAM:   cn_q[i] <= u;
            default: sn_q[i] <= u;
          endcase
        end
      end
      OP_CROSS: begin
        if (!cmd_i.cnt[0]) begin
          xp_q <= p64;
        end else begin
          vec_q[xj] <= xd[64] ? -xq : xq;
        end
      end
      OP_OFFS: begin
        off_q[li] <= sn_q[li][CoordW-1] ? -CoordW'(om) : CoordW'(om);
      end
      OP_EMIT: begin
        if (cmd_i.emit == EM_ERR) begin
          ox_q    <= '0;
          oy_q    <= '0;
          oz_q    <= '0;
          orgba_q <= '0;
          oslot_q <= '0;
          olast_q <= 1'b1;
          ostat_q <= cmd_i.err;
        end else begin
          ox_q    <= vert[0];
          oy_q    <= vert[1];
          oz_q    <= vert[2];
          orgba_q <= color_i;
          oslot_q <= {cmd_i.idx[SlotW-2:0], cmd_i.emit == EM_RIGHT};
          olast_q <= (cmd_i.emit == EM_RIGHT) && cmd_i.pass;
          ostat_q <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.vert_x    = ox_q;
  assign out_o.vert_y    = oy_q;
  assign out_o.vert_z    = oz_q;
  assign out_o.vert_rgba = orgba_q;
  assign out_o.vert_slot = oslot_q;
  assign out_o.run_last  = olast_q;
  assign out_o.status    = ostat_q;

endmodule

@@ rtl/cfre_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfre_ctrl
// Controller: polyline bookkeeping and the step sequence of one expansion.
// ----------------------------------------------------------------------------
module cfre_ctrl import cfre_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_eol_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COMMIT,
    S_ERR,
    S_VLOAD,
    S_MAG,
    S_SQ,
    S_TINY,
    S_SHIFT,
    S_ROOT,
    S_DIV,
    S_STORE,
    S_CROSS,
    S_OFFS,
    S_EMIT_L,
    S_EMIT_R
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] cnt_q;
  logic [CntW-1:0]  n_q;
  logic             eol_q, pass_q, retry_q, norm_q, zero_q;
  vsel_e            vsel_q;
  status_e          err_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_NOP;
    cmd_o.cnt       = cnt_q;
    cmd_o.vsel      = vsel_q;
    cmd_o.retry     = retry_q;
    cmd_o.pass      = pass_q;
    cmd_o.use_older = (n_q >= CntW'(2));
    cmd_o.idx       = pass_q ? n_q : n_q - CntW'(1);
    cmd_o.err       = err_q;
    cmd_o.emit      = EM_LEFT;
    unique case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LATCH : OP_NOP;
      S_COMMIT: cmd_o.op = OP_COMMIT;
      S_ERR: begin
        cmd_o.op   = stat_i.out_free ? OP_EMIT : OP_NOP;
        cmd_o.emit = EM_ERR;
      end
      S_VLOAD:  cmd_o.op = OP_VLOAD;
      S_MAG:    cmd_o.op = OP_MAGLOAD;
      S_SQ:     cmd_o.op = OP_SQ;
      S_TINY:   cmd_o.op = OP_TINY;
      S_SHIFT: begin
        priority if (stat_i.m_zero) cmd_o.op = OP_NOP;
        else if (stat_i.m_hi)       cmd_o.op = OP_SHR;
        else if (stat_i.m_lo)       cmd_o.op = OP_SHL;
        else                        cmd_o.op = OP_NOP;
      end
      S_ROOT:   cmd_o.op = OP_ROOT;
      S_DIV:    cmd_o.op = OP_DIV;
      S_STORE:  cmd_o.op = zero_q ? OP_STORE_ZERO : OP_STORE;
      S_CROSS:  cmd_o.op = OP_CROSS;
      S_OFFS:   cmd_o.op = OP_OFFS;
      S_EMIT_L: cmd_o.op = stat_i.out_free ? OP_EMIT : OP_NOP;
      S_EMIT_R: begin
        cmd_o.op   = stat_i.out_free ? OP_EMIT : OP_NOP;
        cmd_o.emit = EM_RIGHT;
      end
      default:  cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      eol_q   <= 1'b0;
      pass_q  <= 1'b0;
      retry_q <= 1'b0;
      norm_q  <= 1'b0;
      zero_q  <= 1'b0;
      vsel_q  <= V_TAN;
      err_q   <= ST_OK;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            eol_q <= in_eol_i;
            // count stops at the limit; later points only wait for the end marker
            if (n_q >= CntW'(MaxPoints)) begin
              if (in_eol_i) begin
                err_q   <= ST_LONG;
                state_q <= S_ERR;
              end
            end else if (n_q == '0) begin
              if (in_eol_i) begin
                err_q   <= ST_SHORT;
                state_q <= S_ERR;
              end else begin
                state_q <= S_COMMIT;
              end
            end else begin
              pass_q  <= 1'b0;
              vsel_q  <= V_TAN;
              state_q <= S_VLOAD;
            end
          end
        end
        S_COMMIT: begin
          n_q     <= n_q + CntW'(1);
          state_q <= S_IDLE;
        end
        S_ERR: begin
          if (stat_i.out_free) begin
            n_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        S_VLOAD: begin
          norm_q  <= 1'b0;
          retry_q <= 1'b0;
          state_q <= S_MAG;
        end
        S_MAG: begin
          cnt_q   <= '0;
          state_q <= norm_q ? S_SHIFT : S_SQ;
        end
        S_SQ: begin
          if (cnt_q == StepW'(SqSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= norm_q ? S_ROOT : S_TINY;
          end else begin
            cnt_q <= cnt_q + StepW'(1);
          end
        end
        S_TINY: begin
          if (vsel_q == V_SIDE && stat_i.tiny && !retry_q) begin
            retry_q <= 1'b1;
          end else begin
            norm_q <= 1'b1;
          end
          state_q <= S_MAG;
        end
        S_SHIFT: begin
          zero_q <= stat_i.m_zero;
          cnt_q  <= '0;
          if (stat_i.m_zero) begin
            state_q <= S_STORE;
          end else if (!stat_i.m_hi && !stat_i.m_lo) begin
            state_q <= S_SQ;
          end
        end
        S_ROOT: begin
          if (cnt_q == StepW'(RootSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + StepW'(1);
          end
        end
        S_DIV: begin
          if (cnt_q == StepW'(DivSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= S_STORE;
          end else begin
            cnt_q <= cnt_q + StepW'(1);
          end
        end
        S_STORE: begin
          cnt_q <= '0;
          unique case (vsel_q)
            V_TAN: begin
              vsel_q  <= V_CAM;
              state_q <= S_VLOAD;
            end
            V_CAM:   state_q <= S_CROSS;
            default: state_q <= S_OFFS;
          endcase
        end
        S_CROSS: begin
          if (cnt_q == StepW'(CrossSteps - 1)) begin
            cnt_q   <= '0;
            vsel_q  <= V_SIDE;
            norm_q  <= 1'b0;
            retry_q <= 1'b0;
            state_q <= S_MAG;
          end else begin
            cnt_q <= cnt_q + StepW'(1);
          end
        end
        S_OFFS: begin
          if (cnt_q == StepW'(OffsSteps - 1)) begin
            cnt_q   <= '0;
            state_q <= S_EMIT_L;
          end else begin
            cnt_q <= cnt_q + StepW'(1);
          end
        end
        S_EMIT_L: begin
          if (stat_i.out_free) state_q <= S_EMIT_R;
        end
        S_EMIT_R: begin
          if (stat_i.out_free) begin
            if (pass_q) begin
              n_q     <= '0;
              state_q <= S_IDLE;
            end else if (eol_q) begin
              pass_q  <= 1'b1;
              vsel_q  <= V_TAN;
              state_q <= S_VLOAD;
            end else begin
              state_q <= S_COMMIT;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/camera_facing_ribbon_expander_top.sv @@
// ----------------------------------------------------------------------------
// camera_facing_ribbon_expander_top
// Expands a polyline into a camera-facing ribbon: two vertices per point.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one Q16.16 point per word, end_of_line on the final point.
//   out_o carries vertex words: left then right vertex of each point, or a
//   single error word (status short / too long) with run_last set.
//   The APB port holds camera position, ribbon width and color; write it only
//   while the block is idle.
// Timing:
//   A point's vertices appear once its successor arrives. Each expansion runs
//   three vector normalizations on one shared multiplier, a bit-serial square
//   root and three parallel divider lanes; the final point of a polyline runs
//   two expansions. The first point of a polyline is only latched and
//   committed, and an error word is emitted without any expansion.
//   in_i.ready is high only between points; out_o has a one-word output
//   register, so a point may be taken while the last vertex waits.
// Reset:
//   rst_ni clears the polyline state and loads the register defaults. A stall
//   on out_o simply holds the sequence until the word is taken.
module camera_facing_ribbon_expander_top import cfre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  cfre_in_if.sink            in_i,
  cfre_out_if.source         out_o
);

  logic signed [CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [WidthW-1:0]        width_q;
  logic [ColorW-1:0]        color_q;
  reg_e                     reg_idx;
  logic                     wr_en;
  cmd_t                     cmd;
  stat_t                    stat;
  logic                     in_ready;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      width_q <= WidthReset;
      color_q <= ColorReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAM_X: cam_x_q <= pwdata;
        REG_CAM_Y: cam_y_q <= pwdata;
        REG_CAM_Z: cam_z_q <= pwdata;
        REG_WIDTH: width_q <= pwdata[WidthW-1:0];
        REG_COLOR: color_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAM_X: prdata = cam_x_q;
      REG_CAM_Y: prdata = cam_y_q;
      REG_CAM_Z: prdata = cam_z_q;
      REG_WIDTH: prdata = DataW'(width_q);
      REG_COLOR: prdata = color_q;
      default:   prdata = '0;
    endcase
  end

  assign in_i.ready = in_ready;

  cfre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_eol_i   (in_i.end_of_line),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cfre_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .point_x_i (in_i.point_x),
    .point_y_i (in_i.point_y),
    .point_z_i (in_i.point_z),
    .cam_x_i   (cam_x_q),
    .cam_y_i   (cam_y_q),
    .cam_z_i   (cam_z_q),
    .width_i   (width_q),
    .color_i   (color_q),
    .out_o     (out_o)
  );

`ifndef NO_ASSERTIONS
  // error words carry nothing but the status and the end flag
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_OK |-> out_o.run_last && out_o.vert_slot == '0)
    else $error("error word with slot or without run_last");

  // the final vertex of a polyline is always a right-side vertex
  a_last_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_OK && out_o.run_last |-> out_o.vert_slot[0])
    else $error("run_last on a left vertex");

  // no new point is taken while a word is being loaded for output
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_EMIT |-> !in_i.ready)
    else $error("input ready during vertex emit");
`endif

endmodule
